FILE: src/bbc_pkg.sv
// ============================================================================
// Bracket balance checker package
// Shared constants, bracket kind codes, character decoders and result type.
// ============================================================================
`default_nettype none

package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int MAX_LENGTH  = 65536;

    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int COUNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int INDEX_W  = $clog2(MAX_LENGTH + 1);
    localparam int POS_W    = 16;
    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 2;

    localparam logic [CHAR_W-1:0] CHAR_OPEN_ROUND   = 8'h28;
    localparam logic [CHAR_W-1:0] CHAR_CLOSE_ROUND  = 8'h29;
    localparam logic [CHAR_W-1:0] CHAR_OPEN_SQUARE  = 8'h5B;
    localparam logic [CHAR_W-1:0] CHAR_CLOSE_SQUARE = 8'h5D;
    localparam logic [CHAR_W-1:0] CHAR_OPEN_CURLY   = 8'h7B;
    localparam logic [CHAR_W-1:0] CHAR_CLOSE_CURLY  = 8'h7D;

    typedef enum logic [KIND_W-1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic             overflow;
        logic [POS_W-1:0] close_pos;
        logic [POS_W-1:0] open_pos;
        logic             pair_found;
        logic             balanced;
    } result_t;

    function automatic kind_t opener_kind(input logic [CHAR_W-1:0] c);
        kind_t k;
        unique case (c)
            CHAR_OPEN_ROUND:  k = KIND_ROUND;
            CHAR_OPEN_SQUARE: k = KIND_SQUARE;
            CHAR_OPEN_CURLY:  k = KIND_CURLY;
            default:          k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic kind_t closer_kind(input logic [CHAR_W-1:0] c);
        kind_t k;
        unique case (c)
            CHAR_CLOSE_ROUND:  k = KIND_ROUND;
            CHAR_CLOSE_SQUARE: k = KIND_SQUARE;
            CHAR_CLOSE_CURLY:  k = KIND_CURLY;
            default:           k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: src/bbc_ram.sv
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: src/bracket_balance_checker.sv
// ============================================================================
// Bracket balance checker
// Checks bracket nesting of a byte string and reports the outer pair.
// ============================================================================
// Throughput: one byte per cycle while the result skid register is empty; the stack
// top lives in a register and the entry beneath it is prefetched from the stack RAM.
// Result: registered into the output buffer as the last beat is taken.
// Reset: synchronous; clears counters, flags and output buffer. The stack RAM
// needs no clearing pass, as an entry is only read after it has been pushed.
`default_nettype none

module bracket_balance_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last byte of the string
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [0] balanced, [1] pair_found,
                                        // [17:2] open_pos, [33:18] close_pos,
                                        // [34] overflow, [39:35] zero
);

    // ------------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------------
    logic [bbc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [bbc_pkg::INDEX_W-1:0] index_reg, index_next;
    logic [bbc_pkg::POS_W-1:0]   first_reg, first_next;
    logic [bbc_pkg::POS_W-1:0]   close_reg, close_next;
    logic                        seen_reg, seen_next;
    logic                        closed_reg, closed_next;
    logic                        ovf_reg, ovf_next;
    bbc_pkg::kind_t              top_reg, top_next;

    // Two-entry result buffer: main output register plus a skid register, so
    // the input side keeps flowing while one result waits to be taken.
    bbc_pkg::result_t out_reg, out_next;
    bbc_pkg::result_t skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;

    // ------------------------------------------------------------------------
    // Byte decode
    // ------------------------------------------------------------------------
    logic                        accept;
    logic                        too_long;
    bbc_pkg::kind_t              ok;
    bbc_pkg::kind_t              ck;
    logic                        do_push;
    logic                        push_full;
    logic                        do_pop;
    logic [bbc_pkg::COUNT_W-1:0] count_after;
    logic [bbc_pkg::INDEX_W-1:0] index_after;
    logic [bbc_pkg::POS_W-1:0]   first_after;
    logic [bbc_pkg::POS_W-1:0]   close_after;
    logic                        seen_after;
    logic                        closed_after;
    logic                        ovf_after;
    logic [bbc_pkg::POS_W-1:0]   pos16;
    bbc_pkg::result_t            res;
    logic                        res_push;
    logic                        res_pop;

    // Stack RAM ports
    logic                         ram_wr_en;
    logic [bbc_pkg::STACK_AW-1:0] ram_wr_addr;
    logic [bbc_pkg::STACK_AW-1:0] ram_rd_addr;
    logic [bbc_pkg::KIND_W-1:0]   ram_rd_data;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign too_long = (index_reg >= bbc_pkg::INDEX_W'(bbc_pkg::MAX_LENGTH));
    assign ok       = bbc_pkg::opener_kind(s_tdata);
    assign ck       = bbc_pkg::closer_kind(s_tdata);
    assign pos16    = index_reg[bbc_pkg::POS_W-1:0];

    assign do_push   = accept && !too_long && (ok != bbc_pkg::KIND_NONE)
                       && (count_reg < bbc_pkg::COUNT_W'(bbc_pkg::STACK_DEPTH));
    assign push_full = accept && !too_long && (ok != bbc_pkg::KIND_NONE)
                       && (count_reg == bbc_pkg::COUNT_W'(bbc_pkg::STACK_DEPTH));
    // A closer pops only when it pairs with the kind on top of the stack.
    assign do_pop    = accept && !too_long && (ok == bbc_pkg::KIND_NONE)
                       && (count_reg != '0) && (ck != bbc_pkg::KIND_NONE)
                       && (ck == top_reg);

    // State as it stands once the current byte has been taken.
    always_comb begin
        count_after  = count_reg;
        index_after  = index_reg;
        first_after  = first_reg;
        close_after  = close_reg;
        seen_after   = seen_reg;
        closed_after = closed_reg;
        ovf_after    = ovf_reg;
        top_next     = top_reg;

        if (accept && too_long) begin
            ovf_after = 1'b1;
        end
        if (accept && !too_long) begin
            index_after = index_reg + 1'b1;
        end
        if (accept && !too_long && (ok != bbc_pkg::KIND_NONE) && !seen_reg) begin
            seen_after  = 1'b1;
            first_after = pos16;
        end
        if (push_full) begin
            ovf_after = 1'b1;
        end
        if (do_push) begin
            count_after = count_reg + 1'b1;
            top_next    = ok;
        end
        if (do_pop) begin
            count_after = count_reg - 1'b1;
            // The prefetched entry beneath the top becomes the new top.
            top_next    = bbc_pkg::kind_t'(ram_rd_data);
            if ((count_reg == bbc_pkg::COUNT_W'(1)) && seen_reg && !closed_reg) begin
                closed_after = 1'b1;
                close_after  = pos16;
            end
        end
    end

    always_comb begin
        res.balanced   = (count_after == '0) && !ovf_after;
        res.pair_found = closed_after;
        res.open_pos   = seen_after ? first_after : '0;
        res.close_pos  = closed_after ? close_after : '0;
        res.overflow   = ovf_after;
    end

    // A last byte reports and then clears everything for the next string.
    always_comb begin
        if (accept && s_tlast) begin
            count_next  = '0;
            index_next  = '0;
            first_next  = '0;
            close_next  = '0;
            seen_next   = 1'b0;
            closed_next = 1'b0;
            ovf_next    = 1'b0;
        end else begin
            count_next  = count_after;
            index_next  = index_after;
            first_next  = first_after;
            close_next  = close_after;
            seen_next   = seen_after;
            closed_next = closed_after;
            ovf_next    = ovf_after;
        end
    end

    // ------------------------------------------------------------------------
    // Stack RAM: a push writes the new top at its own index; the read port
    // always fetches the entry two below the next count, which is the entry
    // beneath the top in the following cycle. The write and read addresses
    // only coincide when a last byte clears the stack, and the entry read
    // then is never used, so no forwarding is needed.
    // ------------------------------------------------------------------------
    assign ram_wr_en   = do_push;
    assign ram_wr_addr = count_reg[bbc_pkg::STACK_AW-1:0];
    assign ram_rd_addr = bbc_pkg::STACK_AW'(count_next - bbc_pkg::COUNT_W'(2));

    bbc_ram #(
        .WIDTH (bbc_pkg::KIND_W),
        .DEPTH (bbc_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ok),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------------
    // Result buffer
    // ------------------------------------------------------------------------
    assign res_push = accept && s_tlast;
    assign res_pop  = out_valid_reg && m_tready;

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg) begin
            if (res_push) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
        end else if (res_pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = res;
                out_valid_next = res_push;
            end
        end else if (res_push) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg};

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            index_reg      <= '0;
            first_reg      <= '0;
            close_reg      <= '0;
            seen_reg       <= 1'b0;
            closed_reg     <= 1'b0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            count_reg      <= count_next;
            index_reg      <= index_next;
            first_reg      <= first_next;
            close_reg      <= close_next;
            seen_reg       <= seen_next;
            closed_reg     <= closed_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg  <= top_next;
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_bracket_balance_checker.sv
// ============================================================================
// Bracket balance checker testbench
// Drives byte strings into the checker and compares each result beat with a
// behavioural model of the bracket stack kept inside the bench.
// ============================================================================
`default_nettype none

module tb_bracket_balance_checker;

    // One input beat as the bench keeps it. Where literal is set, the result
    // that this beat closes is taken from want rather than from the model.
    typedef struct packed {
        logic [bbc_pkg::CHAR_W-1:0] ch;
        logic                       last;
        logic                       literal;
        bbc_pkg::result_t           want;
    } stim_beat_t;

    // Hand-written results, fields from the top: overflow, close_pos,
    // open_pos, pair_found, balanced.
    localparam bbc_pkg::result_t R_EMPTY    = {1'b0, 16'd0, 16'd0, 1'b0, 1'b1};
    localparam bbc_pkg::result_t R_PAIR01   = {1'b0, 16'd1, 16'd0, 1'b1, 1'b1};
    localparam bbc_pkg::result_t R_OPEN_AT0 = {1'b0, 16'd0, 16'd0, 1'b0, 1'b0};
    localparam bbc_pkg::result_t R_OPEN_AT1 = {1'b0, 16'd0, 16'd1, 1'b0, 1'b0};
    localparam bbc_pkg::result_t R_MODEL    = '0;

    localparam logic [bbc_pkg::CHAR_W-1:0] CHAR_X = 8'h78;
    localparam logic [bbc_pkg::CHAR_W-1:0] CHAR_A = 8'h61;

    localparam int DIRECTED_COUNT = 24;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int IDLE_PERCENT   = 15;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 16;

    // Directed strings. The index within a string restarts after each beat
    // with last set, so the positions below count from the row after one.
    localparam stim_beat_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // Single ordinary byte straight after reset, then the byte extremes.
        {CHAR_X,                     1'b1, 1'b1, R_EMPTY},
        {8'h00,                      1'b1, 1'b1, R_EMPTY},
        {8'hFF,                      1'b1, 1'b1, R_EMPTY},
        // One pair of each kind.
        {bbc_pkg::CHAR_OPEN_ROUND,   1'b0, 1'b0, R_MODEL},
        {bbc_pkg::CHAR_CLOSE_ROUND,  1'b1, 1'b1, R_PAIR01},
        {bbc_pkg::CHAR_OPEN_SQUARE,  1'b0, 1'b0, R_MODEL},
        {bbc_pkg::CHAR_CLOSE_SQUARE, 1'b1, 1'b1, R_PAIR01},
        {bbc_pkg::CHAR_OPEN_CURLY,   1'b0, 1'b0, R_MODEL},
        {bbc_pkg::CHAR_CLOSE_CURLY,  1'b1, 1'b1, R_PAIR01},
        // A closer on an empty stack is ignored.
        {bbc_pkg::CHAR_CLOSE_CURLY,  1'b1, 1'b1, R_EMPTY},
        // A closer of the wrong kind leaves the group open.
        {bbc_pkg::CHAR_OPEN_ROUND,   1'b0, 1'b0, R_MODEL},
        {bbc_pkg::CHAR_CLOSE_SQUARE, 1'b1, 1'b1, R_OPEN_AT0},
        // An unclosed group reports no pair.
        {CHAR_A,                     1'b0, 1'b0, R_MODEL},
        {bbc_pkg::CHAR_OPEN_ROUND,   1'b1, 1'b1, R_OPEN_AT1},
        // Nested groups, then a fresh opener after the outer pair closed.
        {CHAR_A,                     1'b0, 1'b0, R_MODEL},
        {bbc_pkg::CHAR_OPEN_CURLY,   1'b0, 1'b0, R_MODEL},
        {bbc_pkg::CHAR_OPEN_SQUARE,  1'b0, 1'b0, R_MODEL},
        {bbc_pkg::CHAR_CLOSE_SQUARE, 1'b0, 1'b0, R_MODEL},
        {bbc_pkg::CHAR_CLOSE_CURLY,  1'b0, 1'b0, R_MODEL},
        {bbc_pkg::CHAR_OPEN_ROUND,   1'b1, 1'b0, R_MODEL},
        // The outer pair is the first one only.
        {bbc_pkg::CHAR_OPEN_ROUND,   1'b0, 1'b0, R_MODEL},
        {bbc_pkg::CHAR_CLOSE_ROUND,  1'b0, 1'b0, R_MODEL},
        {bbc_pkg::CHAR_OPEN_ROUND,   1'b0, 1'b0, R_MODEL},
        {CHAR_X,                     1'b1, 1'b0, R_MODEL}
    };

    logic                       aclk     = 1'b0;
    logic                       aresetn  = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [bbc_pkg::CHAR_W-1:0] s_tdata  = '0;   // [7:0] char_code
    logic                       s_tlast  = 1'b0; // last byte of the string
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [39:0]                m_tdata;         // [0] balanced, [1] pair_found,
                                                 // [17:2] open_pos,
                                                 // [33:18] close_pos,
                                                 // [34] overflow, [39:35] zero

    bracket_balance_checker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bracket model. Its own copy of the nesting stack and the string state.
    // ------------------------------------------------------------------------
    bbc_pkg::kind_t nest_kinds [bbc_pkg::STACK_DEPTH];
    int             nest_depth      = 0;
    int             byte_pos        = 0;
    int             first_open_at   = 0;
    int             outer_close_at  = 0;
    logic           seen_opener     = 1'b0;
    logic           outer_done      = 1'b0;
    logic           limit_exceeded  = 1'b0;

    // Feeds one accepted byte to the model; returns 1 and fills res when the
    // byte ends a string. The string state is then cleared.
    function automatic logic track_bracket_byte(input logic [bbc_pkg::CHAR_W-1:0] ch,
                                                input logic is_last,
                                                output bbc_pkg::result_t res);
        int             pos;
        logic           is_open;
        bbc_pkg::kind_t k;
        pos     = byte_pos;
        is_open = 1'b0;
        k       = bbc_pkg::KIND_NONE;
        case (ch)
            bbc_pkg::CHAR_OPEN_ROUND: begin
                is_open = 1'b1;
                k       = bbc_pkg::KIND_ROUND;
            end
            bbc_pkg::CHAR_OPEN_SQUARE: begin
                is_open = 1'b1;
                k       = bbc_pkg::KIND_SQUARE;
            end
            bbc_pkg::CHAR_OPEN_CURLY: begin
                is_open = 1'b1;
                k       = bbc_pkg::KIND_CURLY;
            end
            bbc_pkg::CHAR_CLOSE_ROUND:  k = bbc_pkg::KIND_ROUND;
            bbc_pkg::CHAR_CLOSE_SQUARE: k = bbc_pkg::KIND_SQUARE;
            bbc_pkg::CHAR_CLOSE_CURLY:  k = bbc_pkg::KIND_CURLY;
            default:                    k = bbc_pkg::KIND_NONE;
        endcase

        if (pos >= bbc_pkg::MAX_LENGTH) begin
            // Past the length limit the byte only marks overflow.
            limit_exceeded = 1'b1;
        end else begin
            byte_pos = pos + 1;
            if (is_open) begin
                if (!seen_opener) begin
                    seen_opener   = 1'b1;
                    first_open_at = pos;
                end
                if (nest_depth < bbc_pkg::STACK_DEPTH) begin
                    nest_kinds[nest_depth] = k;
                    nest_depth++;
                end else begin
                    limit_exceeded = 1'b1;
                end
            end else if (k != bbc_pkg::KIND_NONE && nest_depth > 0
                         && nest_kinds[nest_depth-1] == k) begin
                nest_depth--;
                if (nest_depth == 0 && !outer_done) begin
                    outer_done     = 1'b1;
                    outer_close_at = pos;
                end
            end
        end

        res = '0;
        if (!is_last)
            return 1'b0;

        res.balanced   = (nest_depth == 0) && !limit_exceeded;
        res.pair_found = outer_done;
        res.open_pos   = seen_opener ? first_open_at[bbc_pkg::POS_W-1:0] : '0;
        res.close_pos  = outer_done ? outer_close_at[bbc_pkg::POS_W-1:0] : '0;
        res.overflow   = limit_exceeded;

        nest_depth     = 0;
        byte_pos       = 0;
        first_open_at  = 0;
        outer_close_at = 0;
        seen_opener    = 1'b0;
        outer_done     = 1'b0;
        limit_exceeded = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    stim_beat_t       byte_queue [$];
    bbc_pkg::result_t pending_results [$];
    int               beats_queued   = 0;
    int               beats_accepted = 0;
    int               random_items   = 0;
    int               hold_at        = 0;
    int               error_count    = 0;
    logic             hold_off       = 1'b0;

    task automatic push_beat(input logic [bbc_pkg::CHAR_W-1:0] ch, input logic is_last);
        stim_beat_t b;
        b         = '0;
        b.ch      = ch;
        b.last    = is_last;
        byte_queue.insert(byte_queue.size(), b);
        beats_queued++;
    endtask

    function automatic logic [bbc_pkg::CHAR_W-1:0] opener_char(input bbc_pkg::kind_t k);
        case (k)
            bbc_pkg::KIND_ROUND:  return bbc_pkg::CHAR_OPEN_ROUND;
            bbc_pkg::KIND_SQUARE: return bbc_pkg::CHAR_OPEN_SQUARE;
            default:              return bbc_pkg::CHAR_OPEN_CURLY;
        endcase
    endfunction

    function automatic logic [bbc_pkg::CHAR_W-1:0] closer_char(input bbc_pkg::kind_t k);
        case (k)
            bbc_pkg::KIND_ROUND:  return bbc_pkg::CHAR_CLOSE_ROUND;
            bbc_pkg::KIND_SQUARE: return bbc_pkg::CHAR_CLOSE_SQUARE;
            default:              return bbc_pkg::CHAR_CLOSE_CURLY;
        endcase
    endfunction

    // Any of the six bracket characters, chosen by sel.
    function automatic logic [bbc_pkg::CHAR_W-1:0] bracket_char(input int sel);
        bbc_pkg::kind_t k;
        k = bbc_pkg::kind_t'(sel % 3);
        return (sel < 3) ? opener_char(k) : closer_char(k);
    endfunction

    // A random byte that is not a bracket of any kind.
    function automatic logic [bbc_pkg::CHAR_W-1:0] filler_byte();
        logic [bbc_pkg::CHAR_W-1:0] ch;
        do begin
            ch = bbc_pkg::CHAR_W'($urandom_range(255));
        end while (ch inside {bbc_pkg::CHAR_OPEN_ROUND, bbc_pkg::CHAR_CLOSE_ROUND,
                              bbc_pkg::CHAR_OPEN_SQUARE, bbc_pkg::CHAR_CLOSE_SQUARE,
                              bbc_pkg::CHAR_OPEN_CURLY, bbc_pkg::CHAR_CLOSE_CURLY});
        return ch;
    endfunction

    // Builds one random string. Most strings are well nested with random
    // filler; the rest are pure noise, a nested string with one byte broken,
    // or a deep string that can run past the stack depth.
    task automatic add_random_string();
        int                         mode;
        int                         len;
        int                         cap;
        int                         open_w;
        int                         r;
        bbc_pkg::kind_t             opens [$];
        logic [bbc_pkg::CHAR_W-1:0] text [$];
        logic [bbc_pkg::CHAR_W-1:0] ch;
        bbc_pkg::kind_t             k;
        mode   = $urandom_range(9);
        len    = (mode == 9) ? $urandom_range(60, 140) : $urandom_range(1, 24);
        cap    = (mode == 9) ? bbc_pkg::STACK_DEPTH + 6 : 8;
        open_w = (mode == 9) ? 55 : 35;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (mode == 7) begin
                ch = (r < 50) ? bracket_char($urandom_range(5))
                              : bbc_pkg::CHAR_W'($urandom_range(255));
            end else if (opens.size() > 0 && opens.size() >= len - i) begin
                ch = closer_char(opens[$]);
                void'(opens.pop_back());
            end else if (r < open_w && opens.size() < cap) begin
                k = bbc_pkg::kind_t'($urandom_range(2));
                opens.insert(opens.size(), k);
                ch = opener_char(k);
            end else if (r < open_w + 30 && opens.size() > 0) begin
                ch = closer_char(opens[$]);
                void'(opens.pop_back());
            end else begin
                ch = filler_byte();
            end
            text.insert(text.size(), ch);
        end
        if (mode == 8)
            text[$urandom_range(len - 1)] = bracket_char($urandom_range(5));
        foreach (text[i])
            push_beat(text[i], i == len - 1);
        random_items += len;
    endtask

    // ------------------------------------------------------------------------
    // Input side. A new beat is offered once the previous one has been taken;
    // the model sees each byte at the edge where its handshake completes.
    // ------------------------------------------------------------------------
    stim_beat_t offered = '0;

    always @(posedge aclk) begin : input_driver
        bbc_pkg::result_t res;
        stim_beat_t       nb;
        logic             calm;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (track_bracket_byte(offered.ch, offered.last, res))
                    pending_results.insert(pending_results.size(),
                                           offered.literal ? offered.want : res);
                beats_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                // A long calm stretch with no random gaps on either side.
                calm = (beats_accepted >= 400) && (beats_accepted < 1400);
                if (byte_queue.size() > 0
                    && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                    nb = byte_queue.pop_front();
                    offered  <= nb;
                    s_tvalid <= 1'b1;
                    s_tdata  <= nb.ch;
                    s_tlast  <= nb.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side. Each result beat is compared field by field with the
    // oldest expectation; the ready line idles at random or during a hold-off.
    // ------------------------------------------------------------------------
    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        bbc_pkg::result_t want;
        bbc_pkg::result_t got;
        logic             calm;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = bbc_pkg::result_t'(m_tdata[34:0]);
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %0h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("balanced",   want.balanced,   got.balanced);
                    check_field("pair_found", want.pair_found, got.pair_found);
                    check_field("open_pos",   want.open_pos,   got.open_pos);
                    check_field("close_pos",  want.close_pos,  got.close_pos);
                    check_field("overflow",   want.overflow,   got.overflow);
                    check_field("padding",    0,               m_tdata[39:35]);
                end
            end
            calm = (beats_accepted >= 400) && (beats_accepted < 1400);
            m_tready <= !hold_off && (calm || $urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Long hold-off on the result side early in the random part, while the
    // input side keeps offering, so that the checker fills and stalls.
    initial begin : hold_off_window
        wait (aresetn);
        while (beats_accepted < hold_at)
            @(negedge aclk);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Main sequence: build every string, release reset, wait for the drain.
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        // Directed table first.
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            byte_queue.insert(byte_queue.size(), DIRECTED_ROWS[i]);
            beats_queued++;
        end

        // Stack full: more openers than the stack holds, then as many closers.
        for (int i = 0; i < bbc_pkg::STACK_DEPTH + 2; i++)
            push_beat(opener_char(bbc_pkg::kind_t'(i % 3)), 1'b0);
        for (int i = bbc_pkg::STACK_DEPTH + 1; i >= 0; i--)
            push_beat(closer_char(bbc_pkg::kind_t'(i % 3)), i == 0);

        // Random strings.
        hold_at = beats_queued + 300;
        while (random_items < RANDOM_ITEMS)
            add_random_string();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (beats_accepted < beats_queued || pending_results.size() > 0)
            @(negedge aclk);
        // Give any stray result beat time to show up.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin : run_limit
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: bracket_balance_checker.f
src/bbc_pkg.sv
src/bbc_ram.sv
src/bracket_balance_checker.sv
tb/sv/tb_bracket_balance_checker.sv
